// File: sv/alpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpg_pkg
// Shared types and constants for the anti-aliased line pixel generator.
// ----------------------------------------------------------------------------
package alpg_pkg;

    localparam int GRID_BITS   = 16;
    localparam int BRIGHT_BITS = 8;
    localparam int SFRAC       = 16;
    localparam int COORD_W     = 24;
    localparam int DIV_STEPS   = 17;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_INV_GRID = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SWAP,
        ST_ORDER,
        ST_DIV,
        ST_ENDPT,
        ST_FIRST
    } state_t;

    typedef struct packed {
        logic       load_en;
        logic       adv_en;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       swap_en;
        logic       order_en;
        logic       div_en;
        logic       endpt_en;
        logic       first_en;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_last;
    } dp_stat_t;

endpackage

// File: sv/alpg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpg_ctrl
// Sequencer: input handshake, segment setup steps and first-pair issue.
// ----------------------------------------------------------------------------
module alpg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  alpg_pkg::dp_stat_t stat,
    output alpg_pkg::dp_cmd_t  cmd
);
    import alpg_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] mcnt_reg, mcnt_next;
    logic       take;

    assign s_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mcnt_reg  <= mcnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mcnt_next  = mcnt_reg;
        case (state_reg)
            ST_IDLE: begin
                mcnt_next = '0;
                if (take && (s_cmd == CMD_LOAD)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3) begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:  state_next = ST_ORDER;
            ST_ORDER: state_next = ST_DIV;
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_ENDPT;
                end
            end
            ST_ENDPT: state_next = ST_FIRST;
            ST_FIRST: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_idx = mcnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_en = take && (s_cmd == CMD_LOAD);
                cmd.adv_en  = take && (s_cmd == CMD_ADVANCE);
            end
            ST_MUL:   cmd.mul_en   = 1'b1;
            ST_SWAP:  cmd.swap_en  = 1'b1;
            ST_ORDER: cmd.order_en = 1'b1;
            ST_DIV:   cmd.div_en   = 1'b1;
            ST_ENDPT: cmd.endpt_en = 1'b1;
            ST_FIRST: cmd.first_en = stat.out_free;
            default:  cmd          = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_first_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIRST && stat.out_free) |=> (state_reg == ST_IDLE))
        else $error("first pair not retired");
    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP) |-> ($past(state_reg) == ST_MUL && $past(mcnt_reg) == 2'd3))
        else $error("grid mapping skipped");
`endif

endmodule

// File: sv/alpg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpg_dp
// Datapath: grid mapping, setup, gradient divider, endpoints, column stepping.
// ----------------------------------------------------------------------------
module alpg_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_wdata,
    input  logic signed [23:0]  s_start_x,
    input  logic signed [23:0]  s_start_y,
    input  logic signed [23:0]  s_end_x,
    input  logic signed [23:0]  s_end_y,
    input  alpg_pkg::dp_cmd_t   cmd,
    output alpg_pkg::dp_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_pix_a_x,
    output logic [15:0]         m_pix_a_y,
    output logic [8:0]          m_bright_a,
    output logic [15:0]         m_pix_b_x,
    output logic [15:0]         m_pix_b_y,
    output logic [8:0]          m_bright_b,
    output logic                m_last
);
    import alpg_pkg::*;

    typedef struct packed {
        logic [16:0]        col;
        logic signed [33:0] yq;
        logic [8:0]         gap_first;
        logic [8:0]         gap_last;
    } ep_t;

    function automatic ep_t endpoint_f(input logic [23:0] xm, input logic [23:0] ym,
                                       input logic signed [17:0] slp);
        logic [24:0]        xs;
        logic signed [25:0] dd;
        logic signed [8:0]  d;
        logic signed [26:0] pr;
        ep_t                r;
        xs = {1'b0, xm} + 25'd128;
        dd = $signed({1'b0, xs[24:8], 8'b0}) - $signed({2'b0, xm});
        d  = dd[8:0];
        pr = slp * d;
        r.col       = xs[24:8];
        r.yq        = $signed({2'b0, ym, 8'b0}) + 34'(pr >>> BRIGHT_BITS);
        r.gap_first = 9'd256 - {1'b0, xs[7:0]};
        r.gap_last  = {1'b0, xs[7:0]};
        return r;
    endfunction

    function automatic logic [15:0] clampg(input logic signed [20:0] v);
        if (v < 0) begin
            return 16'd0;
        end else if (v > 21'sd65535) begin
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

    function automatic logic [8:0] bmul(input logic [8:0] a, input logic [8:0] b);
        logic [17:0] p;
        p = {9'b0, a} * {9'b0, b};
        return p[16:8];
    endfunction

    // configuration
    logic signed [23:0] origin_x_reg, origin_y_reg;
    logic [23:0]        inv_grid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            inv_grid_reg <= 24'd65536;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                REG_INV_GRID: inv_grid_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // grid mapping, one coordinate per cycle
    logic signed [23:0] pt_reg [4];
    logic [23:0]        g_reg  [4];
    logic signed [23:0] mul_p, mul_o;
    logic signed [24:0] mul_d;
    logic [47:0]        mul_prod;
    logic [23:0]        mul_g;

    assign mul_p    = pt_reg[cmd.mul_idx];
    assign mul_o    = cmd.mul_idx[0] ? origin_y_reg : origin_x_reg;
    assign mul_d    = {mul_p[23], mul_p} - {mul_o[23], mul_o};
    assign mul_prod = {24'b0, mul_d[23:0]} * {24'b0, inv_grid_reg};

    always_comb begin
        if (mul_d <= 0) begin
            mul_g = '0;
        end else if (|mul_prod[47:40]) begin
            mul_g = '1;
        end else begin
            mul_g = mul_prod[39:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            pt_reg[0] <= s_start_x;
            pt_reg[1] <= s_start_y;
            pt_reg[2] <= s_end_x;
            pt_reg[3] <= s_end_y;
        end
        if (cmd.mul_en) begin
            g_reg[cmd.mul_idx] <= mul_g;
        end
    end

    // axis selection and ordering
    logic [23:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic        steep_reg;
    logic [23:0] sw_adx, sw_ady;
    logic        sw_steep;
    logic        ord_swap;
    logic [23:0] o_a1, o_b1, o_a2, o_b2, o_dx, o_ady;
    logic signed [24:0] o_dy;

    assign sw_adx   = (g_reg[2] > g_reg[0]) ? g_reg[2] - g_reg[0] : g_reg[0] - g_reg[2];
    assign sw_ady   = (g_reg[3] > g_reg[1]) ? g_reg[3] - g_reg[1] : g_reg[1] - g_reg[3];
    assign sw_steep = sw_ady > sw_adx;

    assign ord_swap = a1_reg > a2_reg;
    assign o_a1     = ord_swap ? a2_reg : a1_reg;
    assign o_b1     = ord_swap ? b2_reg : b1_reg;
    assign o_a2     = ord_swap ? a1_reg : a2_reg;
    assign o_b2     = ord_swap ? b1_reg : b2_reg;
    assign o_dx     = o_a2 - o_a1;
    assign o_dy     = $signed({1'b0, o_b2}) - $signed({1'b0, o_b1});
    assign o_ady    = o_dy[24] ? 24'(-o_dy) : o_dy[23:0];

    // gradient divider, one quotient bit per cycle
    logic [23:0]        dx_reg;
    logic               neg_reg;
    logic [24:0]        rem_reg;
    logic [16:0]        q_reg;
    logic [4:0]         div_cnt_reg;
    logic signed [17:0] slope_reg;
    logic [24:0]        dv_trial;
    logic               dv_ge;
    logic [16:0]        dv_q;

    assign dv_trial = (div_cnt_reg == 5'(DIV_STEPS - 1)) ? rem_reg : {rem_reg[23:0], 1'b0};
    assign dv_ge    = dv_trial >= {1'b0, dx_reg};
    assign dv_q     = {q_reg[15:0], dv_ge};

    always_ff @(posedge aclk) begin
        if (cmd.swap_en) begin
            steep_reg <= sw_steep;
            a1_reg    <= sw_steep ? g_reg[1] : g_reg[0];
            b1_reg    <= sw_steep ? g_reg[0] : g_reg[1];
            a2_reg    <= sw_steep ? g_reg[3] : g_reg[2];
            b2_reg    <= sw_steep ? g_reg[2] : g_reg[3];
        end
        if (cmd.order_en) begin
            a1_reg      <= o_a1;
            b1_reg      <= o_b1;
            a2_reg      <= o_a2;
            b2_reg      <= o_b2;
            dx_reg      <= o_dx;
            neg_reg     <= o_dy[24];
            rem_reg     <= {1'b0, o_ady};
            q_reg       <= '0;
            div_cnt_reg <= 5'(DIV_STEPS - 1);
        end
        if (cmd.div_en) begin
            rem_reg     <= dv_ge ? dv_trial - {1'b0, dx_reg} : dv_trial;
            q_reg       <= dv_q;
            div_cnt_reg <= div_cnt_reg - 5'd1;
            if (div_cnt_reg == 5'd0) begin
                if (dx_reg == '0) begin
                    slope_reg <= 18'sd65536;
                end else if (neg_reg) begin
                    slope_reg <= -$signed({1'b0, dv_q});
                end else begin
                    slope_reg <= $signed({1'b0, dv_q});
                end
            end
        end
    end

    assign stat.div_last = (div_cnt_reg == 5'd0);

    // endpoints
    ep_t                ep1, ep2;
    logic [16:0]        c1_reg, c2_reg;
    logic signed [33:0] yq1_reg, yq2_reg;
    logic [8:0]         g1_reg, g2_reg;

    assign ep1 = endpoint_f(a1_reg, b1_reg, slope_reg);
    assign ep2 = endpoint_f(a2_reg, b2_reg, slope_reg);

    always_ff @(posedge aclk) begin
        if (cmd.endpt_en) begin
            c1_reg  <= ep1.col;
            c2_reg  <= ep2.col;
            yq1_reg <= ep1.yq;
            yq2_reg <= ep2.yq;
            g1_reg  <= ep1.gap_first;
            g2_reg  <= ep2.gap_last;
        end
    end

    // column stepping state
    logic               active_reg, end_pending_reg;
    logic [17:0]        column_reg;
    logic [16:0]        stop_reg;
    logic signed [35:0] inter_reg;
    logic [16:0]        end_major_reg;
    logic signed [17:0] end_minor_reg;
    logic [8:0]         end_lo_reg, end_hi_reg;
    logic [8:0]         fy1, fy2, fyi;
    logic [17:0]        col_n;
    logic               last_end, last_int;

    assign fy1      = {1'b0, yq1_reg[15:8]};
    assign fy2      = {1'b0, yq2_reg[15:8]};
    assign fyi      = {1'b0, inter_reg[15:8]};
    assign col_n    = column_reg + 18'd1;
    assign last_end = col_n >= {1'b0, stop_reg};
    assign last_int = ({1'b0, col_n} + 19'd1) >= {2'b0, stop_reg};

    // result register
    logic               m_valid_reg;
    logic [15:0]        pax_reg, pay_reg, pbx_reg, pby_reg;
    logic [8:0]         ba_reg, bb_reg;
    logic               last_reg;
    logic               fire;
    logic signed [20:0] e_major, e_minor, e_minor1;
    logic [8:0]         e_ba, e_bb;
    logic               e_last;
    logic [15:0]        e_c, e_ra, e_rb;

    assign stat.out_free = !m_valid_reg || m_ready;
    assign fire          = cmd.first_en || (cmd.adv_en && active_reg);

    always_comb begin
        if (cmd.first_en) begin
            e_major = $signed({4'b0, c1_reg});
            e_minor = 21'($signed(yq1_reg[33:16]));
            e_ba    = bmul(9'd256 - fy1, g1_reg);
            e_bb    = bmul(fy1, g1_reg);
            e_last  = 1'b0;
        end else if (end_pending_reg) begin
            e_major = $signed({4'b0, end_major_reg});
            e_minor = 21'(end_minor_reg);
            e_ba    = end_lo_reg;
            e_bb    = end_hi_reg;
            e_last  = last_end;
        end else begin
            e_major = $signed({3'b0, col_n});
            e_minor = 21'($signed(inter_reg[35:16]));
            e_ba    = 9'd256 - fyi;
            e_bb    = fyi;
            e_last  = last_int;
        end
    end

    assign e_minor1 = e_minor + 21'sd1;
    assign e_c      = clampg(e_major);
    assign e_ra     = clampg(e_minor);
    assign e_rb     = clampg(e_minor1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            end_pending_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.first_en) begin
                active_reg      <= 1'b1;
                end_pending_reg <= 1'b1;
            end else if (cmd.adv_en && active_reg) begin
                end_pending_reg <= 1'b0;
                if (e_last) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.first_en) begin
            column_reg    <= {1'b0, c1_reg};
            stop_reg      <= c2_reg;
            inter_reg     <= 36'(yq1_reg) + 36'(slope_reg);
            end_major_reg <= c2_reg;
            end_minor_reg <= yq2_reg[33:16];
            end_lo_reg    <= bmul(9'd256 - fy2, g2_reg);
            end_hi_reg    <= bmul(fy2, g2_reg);
        end else if (cmd.adv_en && active_reg && !end_pending_reg) begin
            column_reg <= col_n;
            inter_reg  <= inter_reg + 36'(slope_reg);
        end
        if (fire) begin
            pax_reg  <= steep_reg ? e_ra : e_c;
            pay_reg  <= steep_reg ? e_c : e_ra;
            pbx_reg  <= steep_reg ? e_rb : e_c;
            pby_reg  <= steep_reg ? e_c : e_rb;
            ba_reg   <= e_ba;
            bb_reg   <= e_bb;
            last_reg <= e_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pix_a_x  = pax_reg;
    assign m_pix_a_y  = pay_reg;
    assign m_bright_a = ba_reg;
    assign m_pix_b_x  = pbx_reg;
    assign m_pix_b_y  = pby_reg;
    assign m_bright_b = bb_reg;
    assign m_last     = last_reg;

`ifndef NO_ASSERTIONS
    a_pending_active: assert property (@(posedge aclk) disable iff (!aresetn)
        end_pending_reg |-> active_reg)
        else $error("endpoint pending without segment");
    a_first_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.first_en |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");
    a_bright_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (ba_reg <= 9'd256 && bb_reg <= 9'd256))
        else $error("coverage out of range");
`endif

endmodule

// File: sv/antialiased_line_pixel_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antialiased_line_pixel_generator_unit
// Anti-aliased (Wu) line pixel-pair generator with world-to-grid mapping.
// ----------------------------------------------------------------------------
// A load transaction runs the setup steps in order once it is accepted: the
// four endpoint coordinates are mapped through one shared multiplier, the axis
// is picked and the endpoints are ordered, the restoring gradient divider runs
// one quotient bit at a time, then the endpoints are formed and the first pair
// is issued once the result side is free. No transaction is accepted during
// that time. An advance transaction is answered at the next edge, so
// advances run at one per cycle while the result side keeps taking them.
// ----------------------------------------------------------------------------
module antialiased_line_pixel_generator_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [23:0] s_start_x,
    input  logic signed [23:0] s_start_y,
    input  logic signed [23:0] s_end_x,
    input  logic signed [23:0] s_end_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_pix_a_x,
    output logic [15:0]        m_pix_a_y,
    output logic [8:0]         m_bright_a,
    output logic [15:0]        m_pix_b_x,
    output logic [15:0]        m_pix_b_y,
    output logic [8:0]         m_bright_b,
    output logic               m_last
);
    import alpg_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    alpg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .stat    (stat),
        .cmd     (cmd)
    );

    alpg_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_start_x  (s_start_x),
        .s_start_y  (s_start_y),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .cmd        (cmd),
        .stat       (stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pix_a_x  (m_pix_a_x),
        .m_pix_a_y  (m_pix_a_y),
        .m_bright_a (m_bright_a),
        .m_pix_b_x  (m_pix_b_x),
        .m_pix_b_y  (m_pix_b_y),
        .m_bright_b (m_bright_b),
        .m_last     (m_last)
    );

endmodule
